// ===== hdl/salru_pkg.sv =====
// Shared geometry, entry layouts and register map of the set-associative
// LRU tag directory. No dependencies; every other file of the block imports it.
package salru_pkg;

	localparam int ADDR_W     = 32;
	localparam int LINE_BYTES = 64;
	localparam int SETS       = 64;
	localparam int WAYS       = 4;

	localparam int OFFSET_W = $clog2(LINE_BYTES);
	localparam int SET_W    = $clog2(SETS);
	localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;
	localparam int LINE_W   = TAG_W + SET_W;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	// Configuration port: one 32-bit register at byte address 0.
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_SEL_W = PADDR_W - 2;
	localparam logic [REG_SEL_W-1:0] REG_WRITE_BACK_MODE = REG_SEL_W'(0);

	// Access kinds.
	localparam logic ACTION_READ  = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	// One place of a set's recency order. The valid bit lives in flip-flops.
	typedef struct packed {
		logic             dirty;
		logic [TAG_W-1:0] tag;
	} place_t;

	// Places of one set, index 0 most recent, WAYS-1 least recent.
	typedef place_t [WAYS-1:0] set_row_t;

	typedef struct packed {
		logic              hit;
		logic              fill_request;
		logic              writeback_valid;
		logic [LINE_W-1:0] writeback_line;
		logic              write_forward;
	} result_t;

endpackage

// ===== hdl/salru_tag_ram.sv =====
// Tag and dirty storage of the directory: one row of places per set.
// Uses salru_pkg for the row layout; one write port and one registered read port.
module salru_tag_ram
	import salru_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_addr,
	output set_row_t         rd_data,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_addr,
	input  set_row_t         wr_data
);

	set_row_t mem [SETS];
	set_row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/salru_lru_update.sv =====
// Tag compare, victim selection and recency reordering for one access.
// Uses salru_pkg; purely combinational, fed by the stage-one registers.
module salru_lru_update
	import salru_pkg::*;
(
	input  set_row_t         row,
	input  logic [WAYS-1:0]  row_valid,
	input  logic [TAG_W-1:0] tag,
	input  logic [SET_W-1:0] set_index,
	input  logic             action,
	input  logic             write_back_mode,
	output set_row_t         new_row,
	output logic [WAYS-1:0]  new_valid,
	output result_t          result
);

	logic [WAYS-1:0]        match;
	logic                   found;
	logic [WAY_W-1:0]       found_way;
	logic [WAY_W-1:0]       sel_way;
	place_t                 moved;
	logic                   victim_dirty;
	logic [LINE_W-1:0]      victim_line;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			match[i] = row_valid[i] && (row[i].tag == tag);
		end
	end

	// The lowest matching place wins; tags of valid places are unique anyway.
	always_comb begin
		found     = 1'b0;
		found_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				found     = 1'b1;
				found_way = WAY_W'(i);
			end
		end
	end

	assign sel_way = found ? found_way : WAY_W'(WAYS - 1);

	always_comb begin
		if (found) begin
			moved = row[found_way];
		end else begin
			moved.dirty = 1'b0;
			moved.tag   = tag;
		end
		if (action == ACTION_WRITE && write_back_mode) begin
			moved.dirty = 1'b1;
		end
	end

	// Places above the selected one slide down by one toward least recent.
	always_comb begin
		new_row[0]   = moved;
		new_valid[0] = 1'b1;
		for (int i = 1; i < WAYS; i++) begin
			if (WAY_W'(i) <= sel_way) begin
				new_row[i]   = row[i-1];
				new_valid[i] = row_valid[i-1];
			end else begin
				new_row[i]   = row[i];
				new_valid[i] = row_valid[i];
			end
		end
	end

	assign victim_dirty = !found && row_valid[WAYS-1] && row[WAYS-1].dirty;
	assign victim_line  = {row[WAYS-1].tag, set_index};

	assign result.hit             = found;
	assign result.fill_request    = !found;
	assign result.writeback_valid = victim_dirty;
	assign result.writeback_line  = victim_dirty ? victim_line : '0;
	assign result.write_forward   = (action == ACTION_WRITE) && !write_back_mode;

endmodule

// ===== hdl/salru_cfg_regs.sv =====
// APB-style configuration register of the directory (write-back mode).
// Uses salru_pkg for the address map.
module salru_cfg_regs
	import salru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic               write_back_mode
);

	logic                 write_back_mode_q;
	logic [REG_SEL_W-1:0] reg_sel;

	assign reg_sel = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_back_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
				&& reg_sel == REG_WRITE_BACK_MODE) begin
			write_back_mode_q <= pwdata[0];
		end
	end

	assign prdata = (reg_sel == REG_WRITE_BACK_MODE)
		? {{(PDATA_W-1){1'b0}}, write_back_mode_q} : '0;

	assign write_back_mode = write_back_mode_q;

endmodule

// ===== hdl/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative LRU tag directory; uses salru_pkg and its submodules.
// Throughput: one access per cycle unless out_ready stalls the output register,
// set by the tag RAM read in the accept cycle and the compare and LRU update in the
// following cycle, with same-set accesses forwarded.
// Reset: valid bits and control clear at once; no clearing pass; write-back mode is on.
module set_assoc_lru_cache_tags
	import salru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [ADDR_W-1:0]  address,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic               fill_request,
	output logic               writeback_valid,
	output logic [LINE_W-1:0]  writeback_line,
	output logic               write_forward,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// The block is a two-register pipeline. In the accept cycle the set index
	// addresses the tag RAM, whose read data is registered together with the
	// access fields into stage one. During stage one the compare and recency
	// update run, the new row is written back and the result is loaded into
	// the output register.

	logic                 write_back_mode;

	logic [SET_W-1:0]     in_set;
	logic [TAG_W-1:0]     in_tag;
	logic                 accept;
	logic                 advance;
	logic                 commit;

	logic                 valid_s1;
	logic                 action_s1;
	logic [SET_W-1:0]     set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic                 byp_hit_s1;
	set_row_t             byp_row_s1;

	set_row_t             ram_row;
	set_row_t             cur_row;
	set_row_t             new_row;
	logic [WAYS-1:0]      new_valid;
	result_t              result;

	// Valid bits are kept in flip-flops so that reset empties every set at once.
	logic [WAYS-1:0]      valid_q [SETS];

	logic                 out_valid_q;
	result_t              result_q;

	assign in_set = address[OFFSET_W +: SET_W];
	assign in_tag = address[ADDR_W-1 -: TAG_W];

	// Stage one moves on whenever the output register is empty or is being
	// drained. Input is refused only while stage one holds an access behind
	// a waiting result; an empty stage one still takes a new transfer.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign commit   = valid_s1 && advance;

	salru_cfg_regs u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.write_back_mode (write_back_mode)
	);

	salru_tag_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_set),
		.rd_data (ram_row),
		.wr_en   (commit),
		.wr_addr (set_s1),
		.wr_data (new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1   <= in_valid;
			// The RAM read in this cycle misses the row that stage one writes
			// at the same edge; remember to use the freshly updated row instead.
			byp_hit_s1 <= commit && (in_set == set_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			set_s1     <= in_set;
			tag_s1     <= in_tag;
			byp_row_s1 <= new_row;
		end
	end

	assign cur_row = byp_hit_s1 ? byp_row_s1 : ram_row;

	salru_lru_update u_update (
		.row             (cur_row),
		.row_valid       (valid_q[set_s1]),
		.tag             (tag_s1),
		.set_index       (set_s1),
		.action          (action_s1),
		.write_back_mode (write_back_mode),
		.new_row         (new_row),
		.new_valid       (new_valid),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SETS; i++) begin
				valid_q[i] <= '0;
			end
		end else if (commit) begin
			valid_q[set_s1] <= new_valid;
		end
	end

	// Output register: holds a finished result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = result_q.hit;
	assign fill_request    = result_q.fill_request;
	assign writeback_valid = result_q.writeback_valid;
	assign writeback_line  = result_q.writeback_line;
	assign write_forward   = result_q.write_forward;

	// Every access either hits or requests a fill, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit != fill_request))
		else $error("hit and fill_request not exclusive");

	// A writeback only comes with an eviction, which only happens on a miss.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && writeback_valid) |-> (fill_request && !hit))
		else $error("writeback without a miss");

	// Input is refused only while stage one holds an item behind a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without cause");

	// A committed access leaves its set's most recent place valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> new_valid[0])
		else $error("updated set lost its most recent entry");

endmodule

// ===== tb/tb_set_assoc_lru_cache_tags.sv =====
// Self-checking testbench for the set-associative LRU tag directory.
// Depends on salru_pkg and the set_assoc_lru_cache_tags RTL; it needs nothing else.
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_tags;
	import salru_pkg::*;

	// Values of the write-back mode register.
	localparam logic MODE_WRITE_THROUGH = 1'b0;
	localparam logic MODE_WRITE_BACK    = 1'b1;

	// Byte addresses on the configuration port. The second one decodes to a
	// register index that does not exist, so a write there must change nothing.
	localparam logic [PADDR_W-1:0] MODE_ADDR   = {REG_WRITE_BACK_MODE, 2'b00};
	localparam logic [PADDR_W-1:0] UNUSED_ADDR = {REG_SEL_W'(1), 2'b00};

	// Length of the long receiver hold-off, in clock cycles.
	localparam int LONG_HOLD_CYCLES = 64;

	// One access as the driver presents it.
	typedef struct {
		logic              act;
		logic [ADDR_W-1:0] addr;
	} access_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACTION_READ;
	logic [ADDR_W-1:0]  address = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit;
	logic               fill_request;
	logic               writeback_valid;
	logic [LINE_W-1:0]  writeback_line;
	logic               write_forward;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	set_assoc_lru_cache_tags u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.address         (address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.fill_request    (fill_request),
		.writeback_valid (writeback_valid),
		.writeback_line  (writeback_line),
		.write_forward   (write_forward),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the tag directory. Each set is kept in recency order:
	// place 0 is the most recently used way, place WAYS-1 the least recent.
	// Invalid places always sit at the old end, so a miss fills them first.
	// ------------------------------------------------------------------
	logic             dir_valid [SETS][WAYS];
	logic             dir_dirty [SETS][WAYS];
	logic [TAG_W-1:0] dir_tag   [SETS][WAYS];
	logic             wb_mode;

	access_t access_queue[$];      // accesses waiting for the driver
	result_t expected_results[$];  // lookup outcomes still owed by the block

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic rx_hold = 1'b0;
	logic long_hold_arm = 1'b0;

	int mismatches = 0;
	int accepted = 0;
	int n_hits = 0;
	int n_fills = 0;
	int n_writebacks = 0;
	int n_forwards = 0;

	// Looks one access up in the shadow directory, updates recency, valid and
	// dirty state the way the block must, and returns the result it owes.
	function automatic result_t access_directory(input logic act,
			input logic [ADDR_W-1:0] addr);
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag_val;
		logic             mv_valid;
		logic             mv_dirty;
		logic [TAG_W-1:0] mv_tag;
		int               found;
		result_t          r;
		set_idx = addr[OFFSET_W +: SET_W];
		tag_val = addr[ADDR_W-1 -: TAG_W];
		r = '0;
		found = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (found < 0 && dir_valid[set_idx][w] && dir_tag[set_idx][w] == tag_val)
				found = w;
		end
		if (found >= 0) begin
			// Hit: lift the matching way to the front, keep the rest in order.
			mv_valid = dir_valid[set_idx][found];
			mv_dirty = dir_dirty[set_idx][found];
			mv_tag   = dir_tag[set_idx][found];
			for (int w = found; w > 0; w--) begin
				dir_valid[set_idx][w] = dir_valid[set_idx][w-1];
				dir_dirty[set_idx][w] = dir_dirty[set_idx][w-1];
				dir_tag[set_idx][w]   = dir_tag[set_idx][w-1];
			end
			dir_valid[set_idx][0] = mv_valid;
			dir_dirty[set_idx][0] = mv_dirty;
			dir_tag[set_idx][0]   = mv_tag;
			r.hit = 1'b1;
		end else begin
			// Miss: the oldest way is evicted; only a valid dirty victim is
			// written back, addressed by its own tag and this set index.
			r.fill_request = 1'b1;
			if (dir_valid[set_idx][WAYS-1] && dir_dirty[set_idx][WAYS-1]) begin
				r.writeback_valid = 1'b1;
				r.writeback_line  = {dir_tag[set_idx][WAYS-1], set_idx};
			end
			for (int w = WAYS - 1; w > 0; w--) begin
				dir_valid[set_idx][w] = dir_valid[set_idx][w-1];
				dir_dirty[set_idx][w] = dir_dirty[set_idx][w-1];
				dir_tag[set_idx][w]   = dir_tag[set_idx][w-1];
			end
			dir_valid[set_idx][0] = 1'b1;
			dir_dirty[set_idx][0] = 1'b0;
			dir_tag[set_idx][0]   = tag_val;
		end
		// A write marks the line dirty in write-back mode. In write-through
		// mode it is forwarded instead, and a line that is already dirty
		// keeps its mark.
		if (act == ACTION_WRITE) begin
			if (wb_mode == MODE_WRITE_BACK)
				dir_dirty[set_idx][0] = 1'b1;
			else
				r.write_forward = 1'b1;
		end
		return r;
	endfunction

	// Most random accesses land on a few sets with a small pool of tags, so
	// that hits, evictions and dirty writebacks are frequent. The pool holds
	// the all-zero and all-one tags. The remaining accesses use fully random
	// addresses, which toggle every address bit.
	function automatic access_t random_access();
		access_t          a;
		logic [TAG_W-1:0] tag_val;
		int               pick;
		pick = $urandom_range(99);
		a.act  = 1'($urandom_range(1));
		a.addr = $urandom;
		if (pick < 85) begin
			case ($urandom_range(6))
				0: tag_val = '0;
				1: tag_val = '1;
				default: tag_val = TAG_W'($urandom_range(5));
			endcase
			a.addr[ADDR_W-1 -: TAG_W] = tag_val;
			if (pick < 60)
				a.addr[OFFSET_W +: SET_W] = SET_W'($urandom_range(3));
		end
		return a;
	endfunction

	task automatic queue_access(input logic act, input logic [ADDR_W-1:0] addr);
		access_t a;
		a.act  = act;
		a.addr = addr;
		access_queue.push_back(a);
	endtask

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			access_queue.push_back(random_access());
	endtask

	// Waits until every queued access has been transferred and every result
	// has come back.
	task automatic wait_drained();
		while (access_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One configuration transfer: a setup phase, then an access phase that
	// completes at the edge where pready is high. Reads of the mode register
	// are checked against the shadow copy.
	task automatic cfg_access(input logic wr, input logic [PADDR_W-1:0] addr_in,
			input logic [PDATA_W-1:0] data_in);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr_in;
		pwdata  <= data_in;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (wr) begin
			if (addr_in[PADDR_W-1:2] == REG_WRITE_BACK_MODE)
				wb_mode = data_in[0];
		end else if (prdata !== PDATA_W'(wb_mode)) begin
			mismatches++;
			$display("%0t: mode register read expected %0h, got %0h",
				$time, PDATA_W'(wb_mode), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_mode(input logic mode);
		cfg_access(1'b1, MODE_ADDR, PDATA_W'(mode));
		cfg_access(1'b0, MODE_ADDR, '0);
	endtask

	// ------------------------------------------------------------------
	// Driver. At each rising edge it first notes whether the current access
	// was transferred (and predicts its result at that moment, with the mode
	// in force), then either holds the offer, presents the next queued access,
	// or idles, depending on the sender's idle rate.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : access_driver
		access_t nxt;
		if (in_valid && in_ready) begin
			expected_results.push_back(access_directory(action, address));
			accepted++;
		end
		if (in_valid && !in_ready) begin
			// Offer stays up with the same payload until it is taken.
		end else if (access_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
			nxt = access_queue.pop_front();
			in_valid <= 1'b1;
			action   <= nxt.act;
			address  <= nxt.addr;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random back-pressure, plus the long hold-off when it is on.
	always @(posedge clk)
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	// The long hold-off counts its own cycles. The sender keeps offering
	// meanwhile, so the block's output stage fills and in_ready must drop.
	initial begin : rx_long_hold
		wait (long_hold_arm);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor. Every result transfer is matched against the oldest
	// outstanding prediction, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with none expected (hit %0b fill %0b)",
					$time, hit, fill_request);
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("fill_request", 32'(want.fill_request), 32'(fill_request));
				check_field("writeback_valid", 32'(want.writeback_valid),
					32'(writeback_valid));
				check_field("writeback_line", 32'(want.writeback_line),
					32'(writeback_line));
				check_field("write_forward", 32'(want.write_forward), 32'(write_forward));
				n_hits       += int'(hit);
				n_fills      += int'(fill_request);
				n_writebacks += int'(writeback_valid);
				n_forwards   += int'(write_forward);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				dir_valid[s][w] = 1'b0;
				dir_dirty[s][w] = 1'b0;
				dir_tag[s][w]   = '0;
			end
		end
		wb_mode = MODE_WRITE_BACK;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The mode register must read back its reset value before any write.
		cfg_access(1'b0, MODE_ADDR, '0);
		set_mode(MODE_WRITE_BACK);

		// Directed part, write-back mode. Set 0 is filled through its empty
		// ways, a hit reorders it, and then three misses evict in LRU order:
		// a dirty line (line address zero), a clean one, and another dirty one.
		queue_access(ACTION_READ,  32'h0000_0000);
		queue_access(ACTION_WRITE, 32'hFFFF_FFFF);
		queue_access(ACTION_WRITE, 32'h0000_003F);
		queue_access(ACTION_READ,  32'h0000_1000);
		queue_access(ACTION_READ,  32'h0000_2000);
		queue_access(ACTION_WRITE, 32'h0000_3000);
		queue_access(ACTION_READ,  32'h0000_1004);
		queue_access(ACTION_READ,  32'h0000_4000);
		queue_access(ACTION_READ,  32'h0000_5000);
		queue_access(ACTION_READ,  32'h0000_6000);
		wait_drained();

		// A write to a register index that does not exist must leave the
		// block in write-back mode; the next write then marks its line dirty.
		cfg_access(1'b1, UNUSED_ADDR, '0);
		cfg_access(1'b0, MODE_ADDR, '0);
		queue_access(ACTION_WRITE, 32'h0000_7000);
		wait_drained();

		// Switch to write-through. The all-ones line in set 63 is still dirty:
		// a forwarded write hit keeps it dirty, and once four new tags push it
		// out it is written back with the largest line address.
		set_mode(MODE_WRITE_THROUGH);
		queue_access(ACTION_WRITE, 32'hFFFF_FFC0);
		queue_access(ACTION_WRITE, 32'h0000_0FC0);
		queue_access(ACTION_READ,  32'h0000_1FC0);
		queue_access(ACTION_READ,  32'h0000_2FC0);
		queue_access(ACTION_READ,  32'h0000_3FC0);
		queue_access(ACTION_WRITE, 32'h0000_7000);
		queue_access(ACTION_WRITE, 32'h8000_0040);
		wait_drained();

		// Random part, write-back mode: the sender idles now and then, the
		// receiver often. Halfway through the sender pauses until every
		// result has come back.
		set_mode(MODE_WRITE_BACK);
		tx_idle_pct = 24;
		rx_idle_pct = 62;
		queue_random(75);
		wait_drained();
		queue_random(75);
		wait_drained();

		// Write-through mode with the idle rates swapped. Lines left dirty
		// by the previous phase are evicted and written back here.
		set_mode(MODE_WRITE_THROUGH);
		tx_idle_pct = 62;
		rx_idle_pct = 24;
		queue_random(150);
		wait_drained();

		// Back to write-back with no idling at all, and one long receiver
		// hold-off at the start while the sender keeps pushing.
		set_mode(MODE_WRITE_BACK);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(150);
		long_hold_arm = 1'b1;
		wait_drained();

		repeat (4) @(posedge clk);
		$display("Checked %0d accesses in both write modes: %0d hits, %0d fills,",
			accepted, n_hits, n_fills);
		$display("%0d dirty writebacks, %0d forwarded writes, %0d mismatches.",
			n_writebacks, n_forwards, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** set_assoc_lru_cache_tags: PASSED **");
		else
			$display("** set_assoc_lru_cache_tags: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#4000000;
		$display("Timeout with %0d results still outstanding.", expected_results.size());
		$display("** set_assoc_lru_cache_tags: FAILED **");
		$finish;
	end

endmodule
